/* rtl/fsmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmf_pkg
// Shared types and constants for the first substring match finder.
// ----------------------------------------------------------------------------
package fsmf_pkg;

    localparam int MAX_PATTERN_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;
    localparam int MATCH_INDEX_W     = 17;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_TEXT   = 2'd2,
        MODE_END    = 2'd3
    } t_mode;

    // per-request control strobes
    typedef struct packed {
        logic clr_pat;
        logic clr_text;
        logic push_pat;
        logic push_text;
    } t_ctl;

endpackage

/* rtl/fsmf_pattern.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmf_pattern
// Pattern store, held newest byte first, with length and overflow flag.
// ----------------------------------------------------------------------------
module fsmf_pattern
    import fsmf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    input  logic [7:0]       i_byte,
    output logic [7:0]       o_pat [MAX_PATTERN],
    output logic [LEN_W-1:0] o_len,
    output logic             o_overflow
);

    logic [7:0]       r_pat [MAX_PATTERN];
    logic [LEN_W-1:0] r_len;
    logic             r_overflow;
    logic             full;

    assign full = (r_len == LEN_W'(MAX_PATTERN));

    // reversed store: r_pat[i] holds pattern byte len-1-i
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr_pat) begin
            r_len      <= '0;
            r_overflow <= 1'b0;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_pat[i] <= '0;
            end
        end else if (i_ctl.push_pat) begin
            if (full) begin
                r_overflow <= 1'b1;
            end else begin
                r_len    <= r_len + 1'b1;
                r_pat[0] <= i_byte;
                for (int i = 1; i < MAX_PATTERN; i++) begin
                    r_pat[i] <= r_pat[i-1];
                end
            end
        end
    end

    assign o_pat      = r_pat;
    assign o_len      = r_len;
    assign o_overflow = r_overflow;

endmodule

/* rtl/fsmf_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmf_window
// Text window shift register and parallel compare against the pattern.
// ----------------------------------------------------------------------------
module fsmf_window
    import fsmf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_pat [MAX_PATTERN],
    input  logic [LEN_W-1:0] i_len,
    output logic             o_hit
);

    logic [7:0]             r_win [MAX_PATTERN];
    logic [7:0]             n_win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] lane_ok;

    // window as it stands after the incoming text byte
    always_comb begin
        n_win[0] = i_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            n_win[i] = r_win[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            lane_ok[i] = (n_win[i] == i_pat[i]) || (LEN_W'(i) >= i_len);
        end
    end

    assign o_hit = (&lane_ok) && (i_len != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr_text) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_ctl.push_text) begin
            r_win <= n_win;
        end
    end

endmodule

/* rtl/first_substring_match_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_substring_match_finder
// Streaming first-occurrence search of a pattern in a byte stream.
// An end-of-text request shows its result in the cycle after it is accepted.
// Throughput: one request per cycle while the input is ready; the window compare is a single pass.
// Input stays ready while the result register is empty or being drained.
// Reset (synchronous, active low) empties the pattern and the text state.
// ----------------------------------------------------------------------------
module first_substring_match_finder
    import fsmf_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_mode,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [MATCH_INDEX_W-1:0] o_match_index,
    output logic                            o_pattern_too_long
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int POS_W = POSITION_BITS + 1;

    t_ctl                     ctl;
    t_mode                    mode;
    logic                     accept;
    logic [7:0]               pat [MAX_PATTERN];
    logic [LEN_W-1:0]         pat_len;
    logic                     pat_ovf;
    logic                     hit;

    logic [POS_W-1:0]         r_pos;
    logic                     r_seen;
    logic [POSITION_BITS-1:0] r_first;
    logic [POS_W-1:0]         pos_next;
    logic                     latch;

    logic                     r_out_valid;
    logic [MATCH_INDEX_W-1:0] r_idx;
    logic                     r_too_long;
    logic [MATCH_INDEX_W-1:0] n_idx;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign mode       = t_mode'(i_mode);

    always_comb begin
        ctl.clr_pat   = accept && (mode == MODE_CLEAR);
        ctl.clr_text  = accept && (mode == MODE_CLEAR || mode == MODE_END);
        ctl.push_pat  = accept && (mode == MODE_APPEND);
        ctl.push_text = accept && (mode == MODE_TEXT);
    end

    fsmf_pattern #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_pattern (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_byte     (i_data_byte),
        .o_pat      (pat),
        .o_len      (pat_len),
        .o_overflow (pat_ovf)
    );

    fsmf_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_byte  (i_data_byte),
        .i_pat   (pat),
        .i_len   (pat_len),
        .o_hit   (hit)
    );

    // position saturates at 2^POSITION_BITS, i.e. when the top bit is set
    assign pos_next = r_pos + 1'b1;
    assign latch    = !r_pos[POS_W-1] && !r_seen && !pat_ovf && (pat_len != '0)
                      && (pos_next >= POS_W'(pat_len)) && hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctl.clr_text) begin
            r_pos   <= '0;
            r_seen  <= 1'b0;
            r_first <= '0;
        end else if (ctl.push_text && !r_pos[POS_W-1]) begin
            r_pos <= pos_next;
            if (latch) begin
                r_seen  <= 1'b1;
                r_first <= POSITION_BITS'(pos_next - POS_W'(pat_len));
            end
        end
    end

    always_comb begin
        if (pat_len == '0 && !pat_ovf) begin
            n_idx = '0;
        end else if (!pat_ovf && r_seen) begin
            n_idx = MATCH_INDEX_W'(r_first);
        end else begin
            n_idx = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && mode == MODE_END) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && mode == MODE_END) begin
            r_idx      <= n_idx;
            r_too_long <= pat_ovf;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_match_index      = signed'(r_idx);
    assign o_pattern_too_long = r_too_long;

endmodule

/* bench/first_substring_match_finder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_substring_match_finder_tb
// Self-checking bench for the first substring match finder. A queue of
// requests (pattern clears and appends, text bytes, end-of-text markers)
// feeds a valid/ready driver with random gaps. A behavioral copy of the search
// predicts each end-of-text result. A monitor with random back-pressure
// compares every result field against the oldest prediction. The last part
// streams short searches back to back with no idling.
// ----------------------------------------------------------------------------
module first_substring_match_finder_tb;
    import fsmf_pkg::*;

    localparam int          PAT_DEPTH  = MAX_PATTERN_DEF;
    localparam int unsigned POS_LIMIT  = 32'd1 << POSITION_BITS_DEF;
    localparam int          N_RANDOM   = 1000;

    typedef struct {
        t_mode      mode;
        logic [7:0] data;
        bit         idle_ok;
    } t_search_req;

    typedef struct {
        logic [MATCH_INDEX_W-1:0] index;
        logic                     too_long;
    } t_match_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        req_valid = 1'b0;
    logic [1:0]  req_mode = MODE_CLEAR;
    logic [7:0]  req_byte = 8'h00;
    logic        rsp_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic signed [MATCH_INDEX_W-1:0] o_match_index;
    logic        o_pattern_too_long;

    t_search_req   pending_requests[$];
    t_match_result expected_matches[$];
    t_search_req   held_req;
    int            send_gap = 0;
    int            sink_stall = 0;
    bit            idle_ok = 1'b0;

    int n_errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_found = 0;
    int n_too_long = 0;

    // search state copy
    logic [7:0]  pat_store[PAT_DEPTH];
    int          pat_len;
    bit          pat_over;
    logic [7:0]  text_win[PAT_DEPTH];
    int unsigned text_pos;
    bit          hit_seen;
    logic [15:0] hit_pos;

    first_substring_match_finder u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (req_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (req_mode),
        .i_data_byte        (req_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (rsp_ready),
        .o_match_index      (o_match_index),
        .o_pattern_too_long (o_pattern_too_long)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void add_req(t_mode mode, logic [7:0] data, bit may_idle);
        t_search_req r;
        r.mode = mode;
        r.data = data;
        r.idle_ok = may_idle;
        pending_requests.push_back(r);
    endfunction

    function automatic void clear_text_state();
        foreach (text_win[k]) text_win[k] = 8'h00;
        text_pos = 0;
        hit_seen = 1'b0;
        hit_pos = '0;
    endfunction

    function automatic void clear_pattern_state();
        foreach (pat_store[k]) pat_store[k] = 8'h00;
        pat_len = 0;
        pat_over = 1'b0;
    endfunction

    function automatic bit window_hit();
        for (int k = 0; k < pat_len; k++) begin
            if (text_win[pat_len - 1 - k] != pat_store[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void advance_search(t_search_req r);
        t_match_result res;
        case (r.mode)
            MODE_CLEAR: begin
                clear_pattern_state();
                clear_text_state();
            end
            MODE_APPEND: begin
                if (pat_len < PAT_DEPTH) begin
                    pat_store[pat_len] = r.data;
                    pat_len++;
                end else begin
                    pat_over = 1'b1;
                end
            end
            MODE_TEXT: begin
                for (int k = PAT_DEPTH - 1; k > 0; k--) text_win[k] = text_win[k - 1];
                text_win[0] = r.data;
                if (text_pos < POS_LIMIT) begin
                    text_pos++;
                    if (!hit_seen && !pat_over && pat_len > 0 && text_pos >= pat_len
                        && window_hit()) begin
                        hit_seen = 1'b1;
                        hit_pos = 16'(text_pos - pat_len);
                    end
                end
            end
            MODE_END: begin
                if (pat_len == 0 && !pat_over) res.index = '0;
                else if (!pat_over && hit_seen) res.index = {1'b0, hit_pos};
                else res.index = '1;
                res.too_long = pat_over;
                expected_matches.push_back(res);
                clear_text_state();
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && o_in_ready) begin
                advance_search(held_req);
                n_requests++;
            end
            if (!req_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    held_req = pending_requests.pop_front();
                    req_mode <= held_req.mode;
                    req_byte <= held_req.data;
                    req_valid <= 1'b1;
                    idle_ok = held_req.idle_ok;
                    if (idle_ok && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 6);
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_match_result e;
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (o_out_valid && rsp_ready) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch($sformatf("unexpected result index=%0d too_long=%0b",
                                              o_match_index, o_pattern_too_long));
                end else begin
                    e = expected_matches.pop_front();
                    n_results++;
                    if (o_match_index !== e.index)
                        report_mismatch($sformatf("match_index %0d, expected %0d",
                                                  o_match_index, $signed(e.index)));
                    if (o_pattern_too_long !== e.too_long)
                        report_mismatch($sformatf("pattern_too_long %0b, expected %0b",
                                                  o_pattern_too_long, e.too_long));
                    if (e.index != '1) n_found++;
                    if (e.too_long) n_too_long++;
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
                if (idle_ok && $urandom_range(0, 6) == 0) sink_stall = $urandom_range(1, 6);
            end
        end
    end

    initial begin
        logic [7:0] sym[4];
        logic [7:0] pat[$];
        int         plen;
        int         tlen;
        int         at;
        int         r;
        int         n_directed;
        bit         may_idle;

        clear_pattern_state();
        clear_text_state();

        // directed: empty pattern, byte extremes, short text, pattern grown mid-text
        add_req(MODE_END, 8'hFF, 1'b1);
        add_req(MODE_APPEND, 8'h00, 1'b1);
        add_req(MODE_APPEND, 8'hFF, 1'b1);
        add_req(MODE_TEXT, 8'hFF, 1'b1);
        add_req(MODE_TEXT, 8'h00, 1'b1);
        add_req(MODE_TEXT, 8'hFF, 1'b1);
        add_req(MODE_END, 8'h00, 1'b1);
        add_req(MODE_TEXT, 8'h00, 1'b1);
        add_req(MODE_END, 8'hA5, 1'b1);
        add_req(MODE_TEXT, 8'h00, 1'b1);
        add_req(MODE_APPEND, 8'h55, 1'b1);
        add_req(MODE_TEXT, 8'hFF, 1'b1);
        add_req(MODE_TEXT, 8'h55, 1'b1);
        add_req(MODE_END, 8'h5A, 1'b1);
        add_req(MODE_TEXT, 8'h00, 1'b1);
        add_req(MODE_CLEAR, 8'hFF, 1'b1);
        add_req(MODE_TEXT, 8'h12, 1'b1);
        add_req(MODE_END, 8'h00, 1'b1);
        n_directed = pending_requests.size();

        // random: mostly well-formed pattern/text/end sequences over small alphabets
        while (pending_requests.size() < n_directed + N_RANDOM) begin
            may_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 8))
                    add_req(t_mode'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            may_idle);
            end else begin
                foreach (sym[k]) sym[k] = 8'($urandom_range(0, 255));
                add_req(MODE_CLEAR, 8'($urandom_range(0, 255)), may_idle);
                r = $urandom_range(0, 19);
                if (r == 0) plen = 0;
                else if (r < 3) plen = $urandom_range(PAT_DEPTH + 1, PAT_DEPTH + 4);
                else if (r < 5) plen = PAT_DEPTH;
                else plen = $urandom_range(1, 6);
                pat.delete();
                for (int i = 0; i < plen; i++) begin
                    pat.push_back(sym[$urandom_range(0, 3)]);
                    add_req(MODE_APPEND, pat[i], may_idle);
                end
                repeat ($urandom_range(1, 4)) begin
                    tlen = $urandom_range(0, 24);
                    at = ($urandom_range(0, 2) != 0) ? $urandom_range(0, tlen) : -1;
                    for (int i = 0; i <= tlen; i++) begin
                        if (i == at) foreach (pat[j]) add_req(MODE_TEXT, pat[j], may_idle);
                        if (i < tlen) add_req(MODE_TEXT, sym[$urandom_range(0, 3)], may_idle);
                        if ($urandom_range(0, 59) == 0)
                            add_req(MODE_APPEND, sym[$urandom_range(0, 3)], may_idle);
                    end
                    add_req(MODE_END, 8'($urandom_range(0, 255)), may_idle);
                end
            end
        end

        // closing stretch, back to back with no idling
        for (int g = 0; g < 4; g++) begin
            foreach (sym[k]) sym[k] = 8'($urandom_range(0, 255));
            add_req(MODE_CLEAR, 8'h00, 1'b0);
            for (int i = 0; i < 3; i++) add_req(MODE_APPEND, sym[i], 1'b0);
            for (int i = 0; i < 20; i++) begin
                if (i == 10) for (int j = 0; j < 3; j++) add_req(MODE_TEXT, sym[j], 1'b0);
                add_req(MODE_TEXT, sym[$urandom_range(0, 3)], 1'b0);
            end
            add_req(MODE_END, 8'h00, 1'b0);
            add_req(MODE_END, 8'hFF, 1'b0);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || req_valid || expected_matches.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d end-of-text results", n_requests, n_results);
        $display("(%0d with a match position, %0d with an overlong pattern)",
                 n_found, n_too_long);
        if (n_errors == 0) begin
            $display("first_substring_match_finder regression: pass");
        end else begin
            $display("first_substring_match_finder regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d requests queued, %0d results outstanding",
                 pending_requests.size(), expected_matches.size());
        $display("first_substring_match_finder regression: fail");
        $finish;
    end

endmodule
